>>> design/seg_clip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seg_clip_pkg
// Types, widths and helper functions for the segment rectangle clipper.
// ----------------------------------------------------------------------------
package seg_clip_pkg;

    localparam int LAT_W      = 31;
    localparam int LON_W      = 32;
    localparam int DLAT_W     = LAT_W + 1;
    localparam int DLON_W     = LON_W + 1;
    localparam int PROD_W     = 64;
    localparam int QUO_W      = 42;              // quotient bits developed
    localparam int REM_W      = 32;              // divisor magnitude width
    localparam int DIV_STEPS  = 3;               // quotient bits per stage
    localparam int DIV_STAGES = QUO_W / DIV_STEPS;
    localparam int SAT_BIT    = 40;              // quotient limit 2^40
    localparam int QS_W       = SAT_BIT + 1;
    localparam int SUM_W      = 43;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    typedef enum logic [1:0] {
        ST_INSIDE  = 2'd0,
        ST_DROPPED = 2'd1,
        ST_CLIPPED = 2'd2,
        ST_NOCROSS = 2'd3
    } clip_status_t;

    typedef enum logic [1:0] {
        REG_TOP    = 2'd0,
        REG_BOTTOM = 2'd1,
        REG_LEFT   = 2'd2,
        REG_RIGHT  = 2'd3
    } reg_index_t;

    localparam logic signed [LAT_W-1:0] TOP_RST    = 31'sd900000000;
    localparam logic signed [LAT_W-1:0] BOTTOM_RST = -31'sd900000000;
    localparam logic signed [LON_W-1:0] LEFT_RST   = -32'sd1800000000;
    localparam logic signed [LON_W-1:0] RIGHT_RST  = 32'sd1800000000;

    // segment after the inside tests and reordering
    typedef struct packed {
        logic                      bin;
        logic                      ein;
        logic signed [LAT_W-1:0]   plat;
        logic signed [LON_W-1:0]   plon;
        logic signed [LAT_W-1:0]   qlat;
        logic signed [LON_W-1:0]   qlon;
        logic signed [DLAT_W-1:0]  dlat;
        logic signed [DLON_W-1:0]  dlon;
    } seg_t;

    // control carried alongside the dividers
    typedef struct packed {
        logic                      bin;
        logic                      ein;
        logic signed [LAT_W-1:0]   plat;
        logic signed [LON_W-1:0]   plon;
        logic signed [LAT_W-1:0]   qlat;
        logic signed [LON_W-1:0]   qlon;
        logic                      dlat_zero;
        logic                      dlon_zero;
        logic signed [LON_W-1:0]   edge_lon;
        logic signed [LAT_W-1:0]   edge_lat;
        logic                      neg_v;
        logic                      neg_h;
    } ctl_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] num;
        logic [QUO_W-1:0] quo;
        logic [REM_W-1:0] den;
        logic             presat;
    } div_t;

    // quotient bits above QUO_W are zero unless the top part is already at least den
    function automatic div_t div_init(input logic [PROD_W-1:0] p,
                                      input logic [REM_W-1:0] d);
        div_t r;
        r.rem    = REM_W'(p[PROD_W-1:QUO_W]);
        r.num    = p[QUO_W-1:0];
        r.quo    = '0;
        r.den    = d;
        r.presat = (REM_W'(p[PROD_W-1:QUO_W]) >= d);
        return r;
    endfunction

    function automatic div_t div_step(input div_t s);
        div_t           r;
        logic [REM_W:0] t;
        logic           qb;
        r = s;
        for (int i = 0; i < DIV_STEPS; i++) begin
            t  = {r.rem, r.num[QUO_W-1]};
            qb = (t >= {1'b0, r.den});
            if (qb)
            begin
                r.rem = REM_W'(t - {1'b0, r.den});
            end
            else
            begin
                r.rem = t[REM_W-1:0];
            end
            r.num = {r.num[QUO_W-2:0], 1'b0};
            r.quo = {r.quo[QUO_W-2:0], qb};
        end
        return r;
    endfunction

    function automatic logic [QS_W-1:0] quo_sat(input div_t s);
        logic sat;
        sat = s.presat || (s.quo > QUO_W'(1) << SAT_BIT);
        return sat ? (QS_W'(1) << SAT_BIT) : s.quo[QS_W-1:0];
    endfunction

endpackage
`default_nettype wire

>>> design/segment_rect_clip.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_rect_clip
// Clips one line segment per cycle against a configured rectangle.
// ----------------------------------------------------------------------------
// A segment beat is taken on any cycle with start high; busy is always low.
// Each segment gives exactly one result, in input order. result_valid is
// registered after the last divider stage and is high for one cycle per result.
// The two 42-bit restoring dividers (vertical and horizontal edge) develop
// 3 quotient bits per stage over 14 stages, after the input, reorder,
// edge-select and multiply stages. The receiver cannot stall; the pipeline
// never holds.
module segment_rect_clip (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   psel,
    input  wire                                   penable,
    input  wire                                   pwrite,
    input  wire  [seg_clip_pkg::ADDR_W-1:0]       paddr,
    input  wire  [seg_clip_pkg::DATA_W-1:0]       pwdata,
    output logic [seg_clip_pkg::DATA_W-1:0]       prdata,
    output logic                                  pready,
    input  wire                                   start,
    input  wire  signed [seg_clip_pkg::LAT_W-1:0] begin_lat,
    input  wire  signed [seg_clip_pkg::LON_W-1:0] begin_lon,
    input  wire  signed [seg_clip_pkg::LAT_W-1:0] end_lat,
    input  wire  signed [seg_clip_pkg::LON_W-1:0] end_lon,
    output logic                                  busy,
    output logic                                  result_valid,
    output logic [1:0]                            clip_status,
    output logic signed [seg_clip_pkg::LAT_W-1:0] out_begin_lat,
    output logic signed [seg_clip_pkg::LON_W-1:0] out_begin_lon,
    output logic signed [seg_clip_pkg::LAT_W-1:0] out_end_lat,
    output logic signed [seg_clip_pkg::LON_W-1:0] out_end_lon
);
    import seg_clip_pkg::*;

    // configuration
    logic signed [LAT_W-1:0] top_reg, bottom_reg;
    logic signed [LON_W-1:0] left_reg, right_reg;
    logic                    cfg_wr;
    reg_index_t              cfg_idx;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg    <= TOP_RST;
            bottom_reg <= BOTTOM_RST;
            left_reg   <= LEFT_RST;
            right_reg  <= RIGHT_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_TOP:    top_reg    <= pwdata[LAT_W-1:0];
                REG_BOTTOM: bottom_reg <= pwdata[LAT_W-1:0];
                REG_LEFT:   left_reg   <= pwdata[LON_W-1:0];
                REG_RIGHT:  right_reg  <= pwdata[LON_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_TOP:    prdata = DATA_W'(top_reg);
            REG_BOTTOM: prdata = DATA_W'(bottom_reg);
            REG_LEFT:   prdata = DATA_W'(left_reg);
            REG_RIGHT:  prdata = DATA_W'(right_reg);
            default:    prdata = '0;
        endcase
    end

    // stage 0: input capture
    logic                    in_vld_reg;
    logic signed [LAT_W-1:0] in_blat_reg, in_elat_reg;
    logic signed [LON_W-1:0] in_blon_reg, in_elon_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        in_blat_reg <= begin_lat;
        in_blon_reg <= begin_lon;
        in_elat_reg <= end_lat;
        in_elon_reg <= end_lon;
    end

    // stage 1: inside tests, put the inside point first, deltas
    logic s1_vld_reg;
    seg_t s1_reg, s1_next;

    always_comb
    begin
        logic bin, ein;
        bin = (in_blat_reg < top_reg) && (in_blat_reg > bottom_reg) &&
              (in_blon_reg > left_reg) && (in_blon_reg < right_reg);
        ein = (in_elat_reg < top_reg) && (in_elat_reg > bottom_reg) &&
              (in_elon_reg > left_reg) && (in_elon_reg < right_reg);
        s1_next.bin = bin;
        s1_next.ein = ein;
        if (!bin)
        begin
            s1_next.plat = in_elat_reg;
            s1_next.plon = in_elon_reg;
            s1_next.qlat = in_blat_reg;
            s1_next.qlon = in_blon_reg;
        end
        else
        begin
            s1_next.plat = in_blat_reg;
            s1_next.plon = in_blon_reg;
            s1_next.qlat = in_elat_reg;
            s1_next.qlon = in_elon_reg;
        end
        s1_next.dlat = DLAT_W'(s1_next.qlat) - DLAT_W'(s1_next.plat);
        s1_next.dlon = DLON_W'(s1_next.qlon) - DLON_W'(s1_next.plon);
    end

    // stage 2: edge choice, offsets to the edges, magnitudes and signs
    logic              s2_vld_reg;
    ctl_t              s2_ctl_reg, s2_ctl_next;
    logic [LON_W-1:0]  s2_mav_reg, s2_mav_next;   // |edge_lon - plon|
    logic [LAT_W-1:0]  s2_mdlat_reg, s2_mdlat_next;
    logic [LAT_W-1:0]  s2_mah_reg, s2_mah_next;   // |edge_lat - plat|
    logic [LON_W-1:0]  s2_mdlon_reg, s2_mdlon_next;

    always_comb
    begin
        logic signed [DLON_W-1:0] av;
        logic signed [DLAT_W-1:0] ah;
        logic                     slat, slon;
        slat = s1_reg.dlat[DLAT_W-1];
        slon = s1_reg.dlon[DLON_W-1];
        s2_ctl_next.bin       = s1_reg.bin;
        s2_ctl_next.ein       = s1_reg.ein;
        s2_ctl_next.plat      = s1_reg.plat;
        s2_ctl_next.plon      = s1_reg.plon;
        s2_ctl_next.qlat      = s1_reg.qlat;
        s2_ctl_next.qlon      = s1_reg.qlon;
        s2_ctl_next.dlat_zero = (s1_reg.dlat == '0);
        s2_ctl_next.dlon_zero = (s1_reg.dlon == '0);
        s2_ctl_next.edge_lon  = slon ? left_reg : right_reg;
        s2_ctl_next.edge_lat  = slat ? bottom_reg : top_reg;
        av = DLON_W'(s2_ctl_next.edge_lon) - DLON_W'(s1_reg.plon);
        ah = DLAT_W'(s2_ctl_next.edge_lat) - DLAT_W'(s1_reg.plat);
        s2_ctl_next.neg_v = av[DLON_W-1] ^ slat ^ slon;
        s2_ctl_next.neg_h = ah[DLAT_W-1] ^ slon ^ slat;
        s2_mav_next   = LON_W'(av[DLON_W-1] ? -av : av);
        s2_mah_next   = LAT_W'(ah[DLAT_W-1] ? -ah : ah);
        s2_mdlat_next = LAT_W'(slat ? -s1_reg.dlat : s1_reg.dlat);
        s2_mdlon_next = LON_W'(slon ? -s1_reg.dlon : s1_reg.dlon);
    end

    // stage 3: products
    logic              s3_vld_reg;
    ctl_t              s3_ctl_reg;
    logic [PROD_W-1:0] s3_pv_reg, s3_ph_reg;
    logic [REM_W-1:0]  s3_dv_reg, s3_dh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_vld_reg;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg       <= s1_next;
        s2_ctl_reg   <= s2_ctl_next;
        s2_mav_reg   <= s2_mav_next;
        s2_mdlat_reg <= s2_mdlat_next;
        s2_mah_reg   <= s2_mah_next;
        s2_mdlon_reg <= s2_mdlon_next;
        s3_ctl_reg   <= s2_ctl_reg;
        s3_pv_reg    <= PROD_W'(s2_mav_reg * {1'b0, s2_mdlat_reg});
        s3_ph_reg    <= PROD_W'({1'b0, s2_mah_reg} * s2_mdlon_reg);
        s3_dv_reg    <= s2_mdlon_reg;
        s3_dh_reg    <= REM_W'(s2_mdlat_reg);
    end

    // divider stages
    logic vld_reg [DIV_STAGES];
    ctl_t ctl_reg [DIV_STAGES];
    div_t dv_reg  [DIV_STAGES];
    div_t dh_reg  [DIV_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= s3_vld_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_reg[0] <= s3_ctl_reg;
        dv_reg[0]  <= div_step(div_init(s3_pv_reg, s3_dv_reg));
        dh_reg[0]  <= div_step(div_init(s3_ph_reg, s3_dh_reg));
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            ctl_reg[i] <= ctl_reg[i-1];
            dv_reg[i]  <= div_step(dv_reg[i-1]);
            dh_reg[i]  <= div_step(dh_reg[i-1]);
        end
    end

    // final stage: add quotients, range checks, result select
    ctl_t                    fc;
    logic [QS_W-1:0]         qv, qh;
    logic signed [SUM_W-1:0] vv, vh;
    logic                    ok_v, ok_h;
    clip_status_t            st_next;
    logic signed [LAT_W-1:0] oblat_next, oqlat_next;
    logic signed [LON_W-1:0] oblon_next, oqlon_next;

    assign fc = ctl_reg[DIV_STAGES-1];
    assign qv = quo_sat(dv_reg[DIV_STAGES-1]);
    assign qh = quo_sat(dh_reg[DIV_STAGES-1]);

    always_comb
    begin
        vv = fc.neg_v ? SUM_W'(fc.plat) - SUM_W'(qv) : SUM_W'(fc.plat) + SUM_W'(qv);
        vh = fc.neg_h ? SUM_W'(fc.plon) - SUM_W'(qh) : SUM_W'(fc.plon) + SUM_W'(qh);
        ok_v = !fc.dlon_zero && (vv < SUM_W'(top_reg)) && (vv > SUM_W'(bottom_reg));
        ok_h = !fc.dlat_zero && (vh > SUM_W'(left_reg)) && (vh < SUM_W'(right_reg));
        oblat_next = fc.plat;
        oblon_next = fc.plon;
        oqlat_next = fc.qlat;
        oqlon_next = fc.qlon;
        if (fc.bin && fc.ein)
        begin
            st_next = ST_INSIDE;
        end
        else if (!fc.bin && !fc.ein)
        begin
            st_next    = ST_DROPPED;
            oblat_next = '0;
            oblon_next = '0;
            oqlat_next = '0;
            oqlon_next = '0;
        end
        else if (fc.dlat_zero && fc.dlon_zero)
        begin
            st_next = ST_NOCROSS;
        end
        else if (ok_v)
        begin
            st_next    = ST_CLIPPED;
            oqlat_next = vv[LAT_W-1:0];
            oqlon_next = fc.edge_lon;
        end
        else if (ok_h)
        begin
            st_next    = ST_CLIPPED;
            oqlat_next = fc.edge_lat;
            oqlon_next = vh[LON_W-1:0];
        end
        else
        begin
            st_next = ST_NOCROSS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= vld_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        clip_status   <= st_next;
        out_begin_lat <= oblat_next;
        out_begin_lon <= oblon_next;
        out_end_lat   <= oqlat_next;
        out_end_lon   <= oqlon_next;
    end

endmodule
`default_nettype wire
